// File: rtl/core/ccsg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register indexes of the center crop scaler.
package ccsg_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int FRAC_BITS = 16;

  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int CRD_W   = $clog2(MAX_DIM);
  localparam int SCALE_W = DIM_W + FRAC_BITS;
  localparam int ACC_W   = DIM_W + SCALE_W;
  localparam int SEL_W   = ACC_W - FRAC_BITS + 1;
  localparam int PROD_W  = DIM_W + SCALE_W;
  localparam int CROP_W  = PROD_W - FRAC_BITS;
  localparam int STEP_W  = $clog2(SCALE_W + 1);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;

  localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = DIM_W'(240);
  localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = DIM_W'(240);
  localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = DIM_W'(96);
  localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = DIM_W'(96);

  localparam logic [7:0] RB_MASK = 8'hF8;
  localparam logic [7:0] G_MASK  = 8'hFC;
  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } dims_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } q_item_t;

endpackage

// File: rtl/core/center_crop_scale_rgb565_gray_core.sv
`timescale 1ns / 1ps
// Top level of the center crop nearest-neighbor scaler from RGB565 to RGB888 and luma.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  pixel_word, frame_start
//   out_     output     out_valid/out_stall red, green, blue, gray, dest_col, dest_row,
//                                           frame_end
//   cfg_     input      cfg_valid/cfg_ready index, data (four size registers)
//
// Pixels stream through a four-entry queue and a result register at one item per cycle
// while nothing stalls. A frame start item holds the back end while the setup runs:
// two bit-serial divisions run in parallel, then two multiply steps and one offset step.
// rst_n is synchronous; it clears all control state and loads the default sizes.
// A stalled result register stops the back end popping; the queue accepts until full.
module center_crop_scale_rgb565_gray_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_pixel_word,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_gray,
  output logic [ccsg_pkg::CRD_W-1:0]      out_dest_col,
  output logic [ccsg_pkg::CRD_W-1:0]      out_dest_row,
  output logic                            out_frame_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccsg_pkg::DIM_W-1:0]      cfg_data
);

  logic [ccsg_pkg::DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [ccsg_pkg::DIM_W-1:0] src_w_eff, src_h_eff;
  ccsg_pkg::dims_t            dims;
  logic                       q_valid;
  logic                       q_pop;
  ccsg_pkg::q_item_t          q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= ccsg_pkg::RST_SOURCE_WIDTH;
      src_h_r <= ccsg_pkg::RST_SOURCE_HEIGHT;
      dst_w_r <= ccsg_pkg::RST_TARGET_WIDTH;
      dst_h_r <= ccsg_pkg::RST_TARGET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccsg_pkg::CFG_SOURCE_WIDTH:  src_w_r <= cfg_data;
        ccsg_pkg::CFG_SOURCE_HEIGHT: src_h_r <= cfg_data;
        ccsg_pkg::CFG_TARGET_WIDTH:  dst_w_r <= cfg_data;
        ccsg_pkg::CFG_TARGET_HEIGHT: dst_h_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sizes are clamped to 1..MAX_DIM, target sizes further to the source size.
  always_comb begin
    src_w_eff = (src_w_r == '0) ? ccsg_pkg::DIM_W'(1) :
                (src_w_r > ccsg_pkg::DIM_W'(ccsg_pkg::MAX_DIM)) ?
                ccsg_pkg::DIM_W'(ccsg_pkg::MAX_DIM) : src_w_r;
    src_h_eff = (src_h_r == '0) ? ccsg_pkg::DIM_W'(1) :
                (src_h_r > ccsg_pkg::DIM_W'(ccsg_pkg::MAX_DIM)) ?
                ccsg_pkg::DIM_W'(ccsg_pkg::MAX_DIM) : src_h_r;
    dims.src_w = src_w_eff;
    dims.src_h = src_h_eff;
    dims.dst_w = (dst_w_r == '0) ? ccsg_pkg::DIM_W'(1) :
                 (dst_w_r > src_w_eff) ? src_w_eff : dst_w_r;
    dims.dst_h = (dst_h_r == '0) ? ccsg_pkg::DIM_W'(1) :
                 (dst_h_r > src_h_eff) ? src_h_eff : dst_h_r;
  end

  ccsg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_word  (in_pixel_word),
    .in_frame_start (in_frame_start),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  ccsg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .dims          (dims),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_gray      (out_gray),
    .out_dest_col  (out_dest_col),
    .out_dest_row  (out_dest_row),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: rtl/core/ccsg_front.sv
`timescale 1ns / 1ps
// Input stage: accepts pixels, expands RGB565 and queues them for the back end.
module ccsg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_pixel_word,
  input  logic                in_frame_start,
  output logic                q_valid,
  output ccsg_pkg::q_item_t   q_item,
  input  logic                q_pop
);

  ccsg_pkg::q_item_t                 queue_r [ccsg_pkg::QDEPTH];
  logic [ccsg_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ccsg_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ccsg_pkg::QCNT_W-1:0]       count_r, count_nxt;
  ccsg_pkg::q_item_t                 new_item;
  logic                              push;

  always_comb begin
    new_item.frame_start = in_frame_start;
    new_item.red         = in_pixel_word[15:8] & ccsg_pkg::RB_MASK;
    new_item.green       = in_pixel_word[10:3] & ccsg_pkg::G_MASK;
    new_item.blue        = {in_pixel_word[4:0], 3'b000} & ccsg_pkg::RB_MASK;
  end

  assign in_stall = (count_r == ccsg_pkg::QCNT_W'(ccsg_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: rtl/core/ccsg_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle for the scale setup.
module ccsg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ccsg_pkg::SCALE_W-1:0]  dividend,
  input  logic [ccsg_pkg::DIM_W-1:0]    divisor,
  output logic                          done,
  output logic [ccsg_pkg::SCALE_W-1:0]  quotient
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [ccsg_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [ccsg_pkg::DIM_W-1:0]      rem_r, rem_nxt;
  logic [ccsg_pkg::DIM_W-1:0]      dvs_r, dvs_nxt;
  logic [ccsg_pkg::SCALE_W-1:0]    quo_r, quo_nxt;
  logic [ccsg_pkg::DIM_W:0]        rem_sh;
  logic [ccsg_pkg::DIM_W:0]        diff;
  logic                            fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[ccsg_pkg::SCALE_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    fits     = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[ccsg_pkg::DIM_W-1:0] : rem_sh[ccsg_pkg::DIM_W-1:0];
      quo_nxt  = {quo_r[ccsg_pkg::SCALE_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == ccsg_pkg::STEP_W'(ccsg_pkg::SCALE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/ccsg_back.sv
`timescale 1ns / 1ps
// Back end: per-frame scale and crop setup, sampling counters and result register.
module ccsg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccsg_pkg::dims_t             dims,
  input  logic                        q_valid,
  input  ccsg_pkg::q_item_t           q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_gray,
  output logic [ccsg_pkg::CRD_W-1:0]  out_dest_col,
  output logic [ccsg_pkg::CRD_W-1:0]  out_dest_row,
  output logic                        out_frame_end
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DIV,
    ST_MULX,
    ST_MULY,
    ST_OFS
  } state_t;

  localparam int DW = ccsg_pkg::DIM_W;
  localparam int CW = ccsg_pkg::CRD_W;
  localparam int SW = ccsg_pkg::SEL_W;
  localparam int FB = ccsg_pkg::FRAC_BITS;

  state_t                          state_r, state_nxt;
  logic                            setup_done_r, setup_done_nxt;
  logic                            frame_active_r, frame_active_nxt;
  logic [CW-1:0]                   src_col_r, src_col_nxt;
  logic [CW-1:0]                   src_row_r, src_row_nxt;
  logic [DW-1:0]                   dst_col_r, dst_col_nxt;
  logic [DW-1:0]                   dst_row_r, dst_row_nxt;
  logic [ccsg_pkg::ACC_W-1:0]      col_acc_r, col_acc_nxt;
  logic [ccsg_pkg::ACC_W-1:0]      row_acc_r, row_acc_nxt;
  logic [ccsg_pkg::SCALE_W-1:0]    scale_r, scale_nxt;
  logic [CW-1:0]                   ofs_x_r, ofs_x_nxt;
  logic [CW-1:0]                   ofs_y_r, ofs_y_nxt;
  logic [ccsg_pkg::CROP_W-1:0]     crop_w_r, crop_w_nxt;
  logic [ccsg_pkg::CROP_W-1:0]     crop_h_r, crop_h_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      red_r, red_nxt;
  logic [7:0]                      green_r, green_nxt;
  logic [7:0]                      blue_r, blue_nxt;
  logic [7:0]                      gray_r, gray_nxt;
  logic [CW-1:0]                   dcol_r, dcol_nxt;
  logic [CW-1:0]                   drow_r, drow_nxt;
  logic                            fend_r, fend_nxt;

  logic                            div_start;
  logic                            dx_done, dy_done;
  logic [ccsg_pkg::SCALE_W-1:0]    qx, qy;
  logic [DW-1:0]                   mul_a;
  logic [ccsg_pkg::PROD_W-1:0]     product;
  logic [DW-1:0]                   sw_m1, sh_m1, tw_m1, th_m1;
  logic [SW-1:0]                   row_sel_raw, row_sel, col_sel_raw, col_sel;
  logic                            row_hit, emit, row_end, frame_done;
  logic                            can_load, begin_setup, pop;
  logic [15:0]                     luma_sum;
  logic [ccsg_pkg::CROP_W-1:0]     crop_w_room, crop_h_room;

  ccsg_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dims.src_w, {FB{1'b0}}}),
    .divisor  (dims.dst_w),
    .done     (dx_done),
    .quotient (qx)
  );

  ccsg_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dims.src_h, {FB{1'b0}}}),
    .divisor  (dims.dst_h),
    .done     (dy_done),
    .quotient (qy)
  );

  always_comb begin
    sw_m1 = dims.src_w - 1'b1;
    sh_m1 = dims.src_h - 1'b1;
    tw_m1 = dims.dst_w - 1'b1;
    th_m1 = dims.dst_h - 1'b1;

    row_sel_raw = SW'(ofs_y_r) + SW'(row_acc_r[ccsg_pkg::ACC_W-1:FB]);
    row_sel     = (row_sel_raw >= SW'(dims.src_h)) ? SW'(sh_m1) : row_sel_raw;
    col_sel_raw = SW'(ofs_x_r) + SW'(col_acc_r[ccsg_pkg::ACC_W-1:FB]);
    col_sel     = (col_sel_raw >= SW'(dims.src_w)) ? SW'(sw_m1) : col_sel_raw;

    row_hit    = (dst_row_r < dims.dst_h) && (SW'(src_row_r) == row_sel);
    emit       = frame_active_r && row_hit && (dst_col_r < dims.dst_w)
                 && (SW'(src_col_r) == col_sel);
    row_end    = ({1'b0, src_col_r} >= sw_m1);
    frame_done = ({1'b0, src_row_r} >= sh_m1);

    luma_sum = ccsg_pkg::LUMA_R * {8'd0, q_item.red}
             + ccsg_pkg::LUMA_G * {8'd0, q_item.green}
             + ccsg_pkg::LUMA_B * {8'd0, q_item.blue};

    mul_a   = (state_r == ST_MULX) ? dims.dst_w : dims.dst_h;
    product = ccsg_pkg::PROD_W'(mul_a) * ccsg_pkg::PROD_W'(scale_r);

    crop_w_room = ccsg_pkg::CROP_W'(dims.src_w) - crop_w_r;
    crop_h_room = ccsg_pkg::CROP_W'(dims.src_h) - crop_h_r;

    can_load    = !out_valid_r || !out_stall;
    begin_setup = (state_r == ST_RUN) && q_valid && q_item.frame_start && !setup_done_r;
    pop         = (state_r == ST_RUN) && q_valid && !begin_setup && can_load;
    div_start   = begin_setup;
  end

  always_comb begin
    state_nxt        = state_r;
    setup_done_nxt   = setup_done_r;
    frame_active_nxt = frame_active_r;
    src_col_nxt      = src_col_r;
    src_row_nxt      = src_row_r;
    dst_col_nxt      = dst_col_r;
    dst_row_nxt      = dst_row_r;
    col_acc_nxt      = col_acc_r;
    row_acc_nxt      = row_acc_r;
    scale_nxt        = scale_r;
    ofs_x_nxt        = ofs_x_r;
    ofs_y_nxt        = ofs_y_r;
    crop_w_nxt       = crop_w_r;
    crop_h_nxt       = crop_h_r;
    out_valid_nxt    = out_valid_r && out_stall;
    red_nxt          = red_r;
    green_nxt        = green_r;
    blue_nxt         = blue_r;
    gray_nxt         = gray_r;
    dcol_nxt         = dcol_r;
    drow_nxt         = drow_r;
    fend_nxt         = fend_r;

    case (state_r)
      ST_RUN: begin
        if (begin_setup) begin
          state_nxt = ST_DIV;
        end else if (pop) begin
          setup_done_nxt = 1'b0;
          if (frame_active_r) begin
            if (emit) begin
              out_valid_nxt = 1'b1;
              red_nxt       = q_item.red;
              green_nxt     = q_item.green;
              blue_nxt      = q_item.blue;
              gray_nxt      = luma_sum[15:8];
              dcol_nxt      = dst_col_r[CW-1:0];
              drow_nxt      = dst_row_r[CW-1:0];
              fend_nxt      = (dst_col_r == tw_m1) && (dst_row_r == th_m1);
              dst_col_nxt   = dst_col_r + 1'b1;
              col_acc_nxt   = col_acc_r + ccsg_pkg::ACC_W'(scale_r);
            end
            if (row_end) begin
              src_col_nxt = '0;
              if (row_hit) begin
                dst_row_nxt = dst_row_r + 1'b1;
                row_acc_nxt = row_acc_r + ccsg_pkg::ACC_W'(scale_r);
                dst_col_nxt = '0;
                col_acc_nxt = '0;
              end
              if (frame_done) begin
                src_row_nxt      = '0;
                frame_active_nxt = 1'b0;
              end else begin
                src_row_nxt = src_row_r + 1'b1;
              end
            end else begin
              src_col_nxt = src_col_r + 1'b1;
            end
          end
        end
      end
      ST_DIV: begin
        if (dx_done) begin
          scale_nxt = (qx < qy) ? qx : qy;
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: begin
        crop_w_nxt = product[ccsg_pkg::PROD_W-1:FB];
        state_nxt  = ST_MULY;
      end
      ST_MULY: begin
        crop_h_nxt = product[ccsg_pkg::PROD_W-1:FB];
        state_nxt  = ST_OFS;
      end
      ST_OFS: begin
        ofs_x_nxt = (crop_w_r <= ccsg_pkg::CROP_W'(dims.src_w)) ? crop_w_room[CW:1] : '0;
        ofs_y_nxt = (crop_h_r <= ccsg_pkg::CROP_W'(dims.src_h)) ? crop_h_room[CW:1] : '0;
        src_col_nxt      = '0;
        src_row_nxt      = '0;
        dst_col_nxt      = '0;
        dst_row_nxt      = '0;
        col_acc_nxt      = '0;
        row_acc_nxt      = '0;
        frame_active_nxt = 1'b1;
        setup_done_nxt   = 1'b1;
        state_nxt        = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RUN;
      setup_done_r   <= 1'b0;
      frame_active_r <= 1'b0;
      src_col_r      <= '0;
      src_row_r      <= '0;
      dst_col_r      <= '0;
      dst_row_r      <= '0;
      col_acc_r      <= '0;
      row_acc_r      <= '0;
      scale_r        <= '0;
      ofs_x_r        <= '0;
      ofs_y_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      setup_done_r   <= setup_done_nxt;
      frame_active_r <= frame_active_nxt;
      src_col_r      <= src_col_nxt;
      src_row_r      <= src_row_nxt;
      dst_col_r      <= dst_col_nxt;
      dst_row_r      <= dst_row_nxt;
      col_acc_r      <= col_acc_nxt;
      row_acc_r      <= row_acc_nxt;
      scale_r        <= scale_nxt;
      ofs_x_r        <= ofs_x_nxt;
      ofs_y_r        <= ofs_y_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crop_w_r <= crop_w_nxt;
    crop_h_r <= crop_h_nxt;
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    gray_r   <= gray_nxt;
    dcol_r   <= dcol_nxt;
    drow_r   <= drow_nxt;
    fend_r   <= fend_nxt;
  end

  assign q_pop         = pop;
  assign out_valid     = out_valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_gray      = gray_r;
  assign out_dest_col  = dcol_r;
  assign out_dest_row  = drow_r;
  assign out_frame_end = fend_r;

  // No item is consumed while the frame setup sequence runs.
  a_no_pop_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !pop)
    else $error("item consumed during frame setup");

  // Both dividers have the same length and finish together.
  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (dx_done == dy_done))
    else $error("scale dividers out of step");

  // A frame start item always runs the setup before it is consumed.
  a_start_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.frame_start) |-> (setup_done_r && frame_active_r))
    else $error("frame start consumed without setup");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(pop && emit))
    else $error("pending result overwritten");

  // The setup ends with a frame in progress and counters cleared.
  a_setup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OFS) |=> (frame_active_r && (src_col_r == '0) && (src_row_r == '0)))
    else $error("frame setup left bad counter state");

endmodule
